### hw/rtl/api_frame_deframer_event_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent check wrappers clocked on clk; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef API_FRAME_DEFRAMER_EVENT_DECODER_CORE_DEFINES_SVH
`define API_FRAME_DEFRAMER_EVENT_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check outside reset
`define AFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every edge, reset included
`define AFD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AFD_ASSERT(lbl, prop, msg)
`define AFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/afd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Frame constants, decode classes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package afd_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
	localparam int CNT_W  = ADDR_W + 1;

	localparam logic [7:0]  FRAME_FLAG = 8'h7E;
	localparam logic [7:0]  TYPE_A     = 8'h8F;
	localparam logic [7:0]  TYPE_B     = 8'h83;
	localparam logic [7:0]  SUM_GOOD   = 8'hFF;
	localparam logic [15:0] SRC_SENSOR = 16'h0008;
	localparam logic [15:0] SRC_EXPL   = 16'h0007;
	localparam logic [15:0] SRC_FLAG_LO = 16'h0001;
	localparam logic [15:0] SRC_FLAG_HI = 16'h0004;
	localparam logic [7:0]  CMD_METAL  = 8'h01;
	localparam logic [7:0]  CMD_RAD    = 8'h05;
	localparam logic [7:0]  CMD_EXPL   = 8'h07;
	localparam logic [7:0]  CMD_BULK   = 8'h01;

	// byte positions inside a frame
	localparam int POS_LEN_HI = 1;
	localparam int POS_LEN_LO = 2;
	localparam int POS_TYPE   = 3;
	localparam int POS_SRC_HI = 4;
	localparam int POS_SRC_LO = 5;
	localparam int POS_CMD_A  = 8;
	localparam int POS_CMD_B  = 10;
	localparam int MIN_SRC_LEN = 6;
	localparam int HDR_BYTES  = 4;
	localparam int SHORT_HOLD = 4;
	localparam int EXP4_BYTES  = 4;
	localparam int EXP16_BYTES = 24;
	localparam int FLAG_BYTES  = 3;

	localparam logic [1:0] KIND_METAL = 2'd0;
	localparam logic [1:0] KIND_RAD   = 2'd1;
	localparam logic [1:0] KIND_EXPL  = 2'd2;

	localparam logic [3:0] LAST_IDX4  = 4'd3;
	localparam logic [3:0] LAST_IDX16 = 4'd15;

	typedef enum logic [2:0] {
		DEC_NONE, DEC_METAL, DEC_RAD, DEC_EXP4, DEC_EXP16, DEC_FLAGS
	} dec_class_t;

	typedef enum logic [1:0] {OFF_HOLD, OFF_SET, OFF_INC, OFF_ADD2} off_op_t;
	typedef enum logic [1:0] {VAL_HOLD, VAL_SINGLE, VAL_HIGH, VAL_LOW} val_op_t;

	typedef struct packed {
		logic              acc_in;
		logic              drop_one;
		logic              drop_len;
		off_op_t           off_op;
		logic [ADDR_W-1:0] off_val;
		logic              lat_lenhi;
		logic              lat_len;
		logic              sum_clr;
		logic              sum_acc;
		val_op_t           val_op;
		logic              lat_m;
		logic              lat_r;
		logic              idx_clr;
		logic              idx_inc;
		logic              out_load;
		logic [1:0]        out_kind;
		logic              out_has;
		logic              out_last;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic              cnt_zero;
		logic              cnt_le4;
		logic              is_start;
		logic              len_big;
		logic              len_short;
		logic              sum_last;
		logic              sum_ok;
		dec_class_t        dclass;
		logic [ADDR_W-1:0] base;
		logic              v_pair;
		logic              v_last;
		logic              flag_m;
		logic              flag_r;
		logic              slot_free;
	} sts_t;

endpackage

### hw/rtl/afd_rx_if.sv
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel carrying one serial byte per transfer.
// ----------------------------------------------------------------------------
interface afd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/afd_ev_if.sv
// ----------------------------------------------------------------------------
// Event result channel
// Valid/ready channel carrying one decoded event value per transfer.
// ----------------------------------------------------------------------------
interface afd_ev_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [15:0] source_id;
	logic [3:0]  value_index;
	logic [15:0] payload_value;
	logic        has_value;
	logic        last_of_event;

	modport source (output valid, output event_kind, output source_id,
		output value_index, output payload_value, output has_value,
		output last_of_event, input ready);
	modport sink (input valid, input event_kind, input source_id,
		input value_index, input payload_value, input has_value,
		input last_of_event, output ready);
endinterface

### hw/rtl/api_frame_deframer_event_decoder_core.sv
// ----------------------------------------------------------------------------
// API frame deframer and event decoder
// Turns a serial byte stream into checked frames and decoded sensor events.
// ----------------------------------------------------------------------------
// Each received byte is appended to a 64-entry circular store; the block then
// scans from the oldest held byte for the 0x7E start byte, reads the length,
// walks the frame checksum and, on a good frame, emits its events through a
// one-entry output register. All store reads go through the single registered
// read port of the store RAM, each read with a request state and a data state.
// After a byte is taken, the scan examines or drops held bytes one by one; then
// come reading the length, the checksum walk over each byte from the frame type
// through the checksum, and decoding. Emission waits while the output register
// holds an event that a stalled sink has not taken. A byte is taken only while
// the controller is idle; results wait in the output register while the next
// byte is taken.
`include "api_frame_deframer_event_decoder_core_defines.svh"

module api_frame_deframer_event_decoder_core (
	input  logic     clk,
	input  logic     arst_n,
	afd_rx_if.sink   rx,
	afd_ev_if.source ev
);

	afd_pkg::cmd_t cmd;
	afd_pkg::sts_t sts;
	logic          in_ready;

	assign rx.ready = in_ready;

	afd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	afd_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (rx.rx_byte),
		.cmd     (cmd),
		.sts     (sts),
		.ev      (ev)
	);

	// checks
	`AFD_ASSERT_ALWAYS(a_count_bound, sts.count <= 7'd64, "held count beyond store")
	`AFD_ASSERT(a_idle_no_emit, rx.ready |-> !cmd.out_load, "emit while idle")
	`AFD_ASSERT(a_load_free, cmd.out_load |-> (!ev.valid || ev.ready), "result overwritten")
	`AFD_ASSERT(a_scan_after_byte, (rx.valid && rx.ready) |=> !rx.ready, "byte not scanned")

endmodule

### hw/rtl/afd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module afd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/afd_ctrl.sv
// ----------------------------------------------------------------------------
// Deframer controller
// Sequences store scan, length check, checksum walk and event emission.
// ----------------------------------------------------------------------------
module afd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  afd_pkg::sts_t sts,
	output afd_pkg::cmd_t cmd
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_SCAN_RQ = 5'd1;
	localparam logic [4:0] S_SCAN    = 5'd2;
	localparam logic [4:0] S_LEN1_RQ = 5'd3;
	localparam logic [4:0] S_LEN1    = 5'd4;
	localparam logic [4:0] S_LEN2_RQ = 5'd5;
	localparam logic [4:0] S_LEN2    = 5'd6;
	localparam logic [4:0] S_SUM_RQ  = 5'd7;
	localparam logic [4:0] S_SUM     = 5'd8;
	localparam logic [4:0] S_DEC     = 5'd9;
	localparam logic [4:0] S_ONE     = 5'd10;
	localparam logic [4:0] S_V_RQ    = 5'd11;
	localparam logic [4:0] S_V_HI    = 5'd12;
	localparam logic [4:0] S_V_RQ2   = 5'd13;
	localparam logic [4:0] S_V_LO    = 5'd14;
	localparam logic [4:0] S_V_OUT   = 5'd15;
	localparam logic [4:0] S_F_RQ0   = 5'd16;
	localparam logic [4:0] S_F0      = 5'd17;
	localparam logic [4:0] S_F_RQ2   = 5'd18;
	localparam logic [4:0] S_F2      = 5'd19;
	localparam logic [4:0] S_F_OUTM  = 5'd20;
	localparam logic [4:0] S_F_OUTR  = 5'd21;

	logic [4:0] state_q;
	logic [4:0] state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.off_op = afd_pkg::OFF_HOLD;
		cmd.val_op = afd_pkg::VAL_HOLD;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.acc_in = 1'b1;
					cmd.off_op = afd_pkg::OFF_SET;
					state_d = S_SCAN_RQ;
				end
			end
			S_SCAN_RQ: begin
				state_d = sts.cnt_zero ? S_IDLE : S_SCAN;
			end
			S_SCAN: begin
				if (!sts.is_start) begin
					cmd.drop_one = 1'b1;
					state_d = S_SCAN_RQ;
				end else if (sts.cnt_le4) begin
					state_d = S_IDLE;
				end else begin
					cmd.off_op = afd_pkg::OFF_SET;
					cmd.off_val = afd_pkg::ADDR_W'(afd_pkg::POS_LEN_HI);
					state_d = S_LEN1_RQ;
				end
			end
			S_LEN1_RQ: state_d = S_LEN1;
			S_LEN1: begin
				cmd.lat_lenhi = 1'b1;
				cmd.off_op = afd_pkg::OFF_SET;
				cmd.off_val = afd_pkg::ADDR_W'(afd_pkg::POS_LEN_LO);
				state_d = S_LEN2_RQ;
			end
			S_LEN2_RQ: state_d = S_LEN2;
			S_LEN2: begin
				if (sts.len_big) begin
					cmd.drop_one = 1'b1;
					cmd.off_op = afd_pkg::OFF_SET;
					state_d = S_SCAN_RQ;
				end else if (sts.len_short) begin
					state_d = S_IDLE;
				end else begin
					cmd.lat_len = 1'b1;
					cmd.sum_clr = 1'b1;
					cmd.off_op = afd_pkg::OFF_SET;
					cmd.off_val = afd_pkg::ADDR_W'(afd_pkg::POS_TYPE);
					state_d = S_SUM_RQ;
				end
			end
			S_SUM_RQ: state_d = S_SUM;
			S_SUM: begin
				cmd.sum_acc = 1'b1;
				if (!sts.sum_last) begin
					cmd.off_op = afd_pkg::OFF_INC;
					state_d = S_SUM_RQ;
				end else if (sts.sum_ok) begin
					state_d = S_DEC;
				end else begin
					cmd.drop_one = 1'b1;
					cmd.off_op = afd_pkg::OFF_SET;
					state_d = S_SCAN_RQ;
				end
			end
			S_DEC: begin
				unique case (sts.dclass)
					afd_pkg::DEC_METAL, afd_pkg::DEC_RAD: state_d = S_ONE;
					afd_pkg::DEC_EXP4, afd_pkg::DEC_EXP16: begin
						cmd.off_op = afd_pkg::OFF_SET;
						cmd.off_val = sts.base;
						cmd.idx_clr = 1'b1;
						state_d = S_V_RQ;
					end
					afd_pkg::DEC_FLAGS: begin
						cmd.off_op = afd_pkg::OFF_SET;
						cmd.off_val = sts.base;
						state_d = S_F_RQ0;
					end
					default: begin
						cmd.drop_len = 1'b1;
						cmd.off_op = afd_pkg::OFF_SET;
						state_d = S_SCAN_RQ;
					end
				endcase
			end
			S_ONE: begin
				if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = (sts.dclass == afd_pkg::DEC_METAL) ?
						afd_pkg::KIND_METAL : afd_pkg::KIND_RAD;
					cmd.out_last = 1'b1;
					cmd.drop_len = 1'b1;
					cmd.off_op = afd_pkg::OFF_SET;
					state_d = S_SCAN_RQ;
				end
			end
			S_V_RQ: state_d = S_V_HI;
			S_V_HI: begin
				if (sts.v_pair) begin
					cmd.val_op = afd_pkg::VAL_HIGH;
					cmd.off_op = afd_pkg::OFF_INC;
					state_d = S_V_RQ2;
				end else begin
					cmd.val_op = afd_pkg::VAL_SINGLE;
					state_d = S_V_OUT;
				end
			end
			S_V_RQ2: state_d = S_V_LO;
			S_V_LO: begin
				cmd.val_op = afd_pkg::VAL_LOW;
				state_d = S_V_OUT;
			end
			S_V_OUT: begin
				if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = afd_pkg::KIND_EXPL;
					cmd.out_has = 1'b1;
					cmd.out_last = sts.v_last;
					if (sts.v_last) begin
						cmd.drop_len = 1'b1;
						cmd.off_op = afd_pkg::OFF_SET;
						state_d = S_SCAN_RQ;
					end else begin
						cmd.idx_inc = 1'b1;
						cmd.off_op = afd_pkg::OFF_INC;
						state_d = S_V_RQ;
					end
				end
			end
			S_F_RQ0: state_d = S_F0;
			S_F0: begin
				cmd.lat_m = 1'b1;
				cmd.off_op = afd_pkg::OFF_ADD2;
				state_d = S_F_RQ2;
			end
			S_F_RQ2: state_d = S_F2;
			S_F2: begin
				cmd.lat_r = 1'b1;
				state_d = S_F_OUTM;
			end
			S_F_OUTM: begin
				if (!sts.flag_m) begin
					state_d = S_F_OUTR;
				end else if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = afd_pkg::KIND_METAL;
					cmd.out_last = 1'b1;
					state_d = S_F_OUTR;
				end
			end
			S_F_OUTR: begin
				if (!sts.flag_r || sts.slot_free) begin
					cmd.out_load = sts.flag_r;
					cmd.out_kind = afd_pkg::KIND_RAD;
					cmd.out_last = 1'b1;
					cmd.drop_len = 1'b1;
					cmd.off_op = afd_pkg::OFF_SET;
					state_d = S_SCAN_RQ;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### hw/rtl/afd_dp.sv
// ----------------------------------------------------------------------------
// Deframer datapath
// Circular byte store, frame length and checksum, decode fields, result register.
// ----------------------------------------------------------------------------
module afd_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    rx_byte,
	input  afd_pkg::cmd_t cmd,
	output afd_pkg::sts_t sts,
	afd_ev_if.source      ev
);

	localparam int AW = afd_pkg::ADDR_W;
	localparam int CW = afd_pkg::CNT_W;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] off_q;
	logic [7:0]    lenhi_q;
	logic [CW-1:0] len_q;
	logic [7:0]    sum_q;
	logic [7:0]    type_q;
	logic [7:0]    srchi_q;
	logic [7:0]    srclo_q;
	logic [7:0]    cmda_q;
	logic [7:0]    cmdb_q;
	logic [15:0]   val_q;
	logic [3:0]    idx_q;
	logic          m_q;
	logic          r_q;
	logic          ev_valid_q;
	logic [1:0]    kind_q;
	logic [3:0]    oidx_q;
	logic [15:0]   oval_q;
	logic          has_q;
	logic          last_q;
	logic [15:0]   src_out_q;

	logic [7:0]    rdata;
	logic [16:0]   len_full;
	logic          cnt_full;
	logic [8:0]    sum_next;
	logic [15:0]   src;
	logic          ds_b;
	logic [CW-1:0] ds_pos;
	logic [CW-1:0] base;
	logic [7:0]    cmd_byte;
	afd_pkg::dec_class_t dclass;

	// byte store
	afd_ram #(.WIDTH(8), .DEPTH(afd_pkg::MAX_FRAME_BYTES)) u_store (
		.clk   (clk),
		.we    (cmd.acc_in),
		.waddr (head_q + count_q[AW-1:0]),
		.wdata (rx_byte),
		.raddr (head_q + off_q),
		.rdata (rdata)
	);

	assign cnt_full = (count_q == CW'(afd_pkg::MAX_FRAME_BYTES));
	assign len_full = {1'b0, lenhi_q, rdata} + 17'(afd_pkg::HDR_BYTES);
	assign sum_next = {1'b0, sum_q} + {1'b0, rdata};

	// advance store window, read offset and checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			off_q   <= '0;
			sum_q   <= '0;
		end else begin
			if (cmd.acc_in) begin
				if (cnt_full) begin
					head_q <= head_q + AW'(1);
				end else begin
					count_q <= count_q + CW'(1);
				end
			end else if (cmd.drop_one) begin
				head_q  <= head_q + AW'(1);
				count_q <= count_q - CW'(1);
			end else if (cmd.drop_len) begin
				head_q  <= head_q + len_q[AW-1:0];
				count_q <= count_q - len_q;
			end
			unique case (cmd.off_op)
				afd_pkg::OFF_SET:  off_q <= cmd.off_val;
				afd_pkg::OFF_INC:  off_q <= off_q + AW'(1);
				afd_pkg::OFF_ADD2: off_q <= off_q + AW'(2);
				default:           off_q <= off_q;
			endcase
			if (cmd.sum_clr) begin
				sum_q <= '0;
			end else if (cmd.sum_acc) begin
				sum_q <= sum_next[7:0];
			end
		end
	end

	// capture length, header fields, payload values and flag bits
	always_ff @(posedge clk) begin
		if (cmd.lat_lenhi) lenhi_q <= rdata;
		if (cmd.lat_len) len_q <= len_full[CW-1:0];
		if (cmd.sum_acc) begin
			if (off_q == AW'(afd_pkg::POS_TYPE))   type_q  <= rdata;
			if (off_q == AW'(afd_pkg::POS_SRC_HI)) srchi_q <= rdata;
			if (off_q == AW'(afd_pkg::POS_SRC_LO)) srclo_q <= rdata;
			if (off_q == AW'(afd_pkg::POS_CMD_A))  cmda_q  <= rdata;
			if (off_q == AW'(afd_pkg::POS_CMD_B))  cmdb_q  <= rdata;
		end
		unique case (cmd.val_op)
			afd_pkg::VAL_SINGLE: val_q <= {8'h00, rdata};
			afd_pkg::VAL_HIGH:   val_q <= {rdata, 8'h00};
			afd_pkg::VAL_LOW:    val_q[7:0] <= rdata;
			default:             val_q <= val_q;
		endcase
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 4'd1;
		end
		if (cmd.lat_m) m_q <= rdata[7];
		if (cmd.lat_r) r_q <= rdata[7];
	end

	// classify the accepted frame
	assign src      = {srchi_q, srclo_q};
	assign ds_b     = (type_q == afd_pkg::TYPE_B);
	assign ds_pos   = ds_b ? CW'(afd_pkg::POS_CMD_B) : CW'(afd_pkg::POS_CMD_A);
	assign base     = ds_pos + CW'(1);
	assign cmd_byte = ds_b ? cmdb_q : cmda_q;

	always_comb begin
		dclass = afd_pkg::DEC_NONE;
		if ((type_q == afd_pkg::TYPE_A || ds_b) &&
			len_q >= CW'(afd_pkg::MIN_SRC_LEN) && len_q > ds_pos) begin
			if (src == afd_pkg::SRC_SENSOR) begin
				if (cmd_byte == afd_pkg::CMD_METAL) begin
					dclass = afd_pkg::DEC_METAL;
				end else if (cmd_byte == afd_pkg::CMD_RAD) begin
					dclass = afd_pkg::DEC_RAD;
				end else if (cmd_byte == afd_pkg::CMD_EXPL &&
					base + CW'(afd_pkg::EXP4_BYTES) <= len_q) begin
					dclass = afd_pkg::DEC_EXP4;
				end
			end else if (src == afd_pkg::SRC_EXPL) begin
				if (cmd_byte == afd_pkg::CMD_BULK &&
					base + CW'(afd_pkg::EXP16_BYTES) <= len_q) begin
					dclass = afd_pkg::DEC_EXP16;
				end
			end else if (src >= afd_pkg::SRC_FLAG_LO && src <= afd_pkg::SRC_FLAG_HI) begin
				if (base + CW'(afd_pkg::FLAG_BYTES) <= len_q) begin
					dclass = afd_pkg::DEC_FLAGS;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ev_valid_q <= 1'b1;
		end else if (ev.ready) begin
			ev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q <= cmd.out_kind;
			oidx_q <= cmd.out_has ? idx_q : 4'd0;
			oval_q <= cmd.out_has ? val_q : 16'd0;
			has_q  <= cmd.out_has;
			last_q <= cmd.out_last;
		end
	end

	assign ev.valid         = ev_valid_q;
	assign ev.event_kind    = kind_q;
	assign ev.source_id     = src_out_q;
	assign ev.value_index   = oidx_q;
	assign ev.payload_value = oval_q;
	assign ev.has_value     = has_q;
	assign ev.last_of_event = last_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) src_out_q <= src;
	end

	// status to the controller
	always_comb begin
		sts.count     = count_q;
		sts.cnt_zero  = (count_q == '0);
		sts.cnt_le4   = (count_q <= CW'(afd_pkg::SHORT_HOLD));
		sts.is_start  = (rdata == afd_pkg::FRAME_FLAG);
		sts.len_big   = (len_full > 17'(afd_pkg::MAX_FRAME_BYTES));
		sts.len_short = (count_q < len_full[CW-1:0]);
		sts.sum_last  = ({1'b0, off_q} == len_q - CW'(1));
		sts.sum_ok    = (sum_next[7:0] == afd_pkg::SUM_GOOD);
		sts.dclass    = dclass;
		sts.base      = base[AW-1:0];
		sts.v_pair    = (dclass == afd_pkg::DEC_EXP16) && idx_q[1];
		sts.v_last    = (dclass == afd_pkg::DEC_EXP16) ?
			(idx_q == afd_pkg::LAST_IDX16) : (idx_q == afd_pkg::LAST_IDX4);
		sts.flag_m    = m_q;
		sts.flag_r    = r_q;
		sts.slot_free = !ev_valid_q || ev.ready;
	end

endmodule
